FILE: hdl/ramped_setpoint_pid_lift_core_defines.svh
// Assertion macros for the lift controller RTL, used by its sequencer.
`ifndef RAMPED_SETPOINT_PID_LIFT_CORE_DEFINES_SVH
`define RAMPED_SETPOINT_PID_LIFT_CORE_DEFINES_SVH

// Implication checked every clock, held off while in reset.
`define RSPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next clock cycle.
`define RSPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rspl_pkg.sv
// Shared widths, register indexes, config and command types for the lift controller.
package rspl_pkg;

  // position and arithmetic widths
  localparam int POS_W      = 20;
  localparam int ERR_W      = POS_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int SUM_W      = 40;
  localparam int STICK_W    = 16;
  localparam int EXC_W      = STICK_W + 1;
  localparam int Q_SHIFT    = 15;
  localparam int ST_W       = POS_W + STICK_W;
  localparam int ST_RANGE_W = POS_W + Q_SHIFT;
  localparam int PWR_W      = 16;
  localparam int PWR_SHIFT  = 9;
  localparam int ACC_W      = 64;

  // shared multiplier: gain side and operand side
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int HI_W    = 8;
  localparam int PH_W    = 32;
  localparam int LO_SPLIT = 32;

  // integrator term clamp
  localparam logic signed [PH_W-1:0]  INTEG_LIMIT = 32'sd268435456;
  localparam logic signed [ACC_W-1:0] INTEG_CLAMP = 64'sd1152921504606846976;

  // config register widths
  localparam int DEAD_W  = 15;
  localparam int SGAIN_W = 16;
  localparam int STEP_W  = 12;
  localparam int BAND_W  = 16;
  localparam int GAIN_W  = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KF         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd7;

  localparam logic [DEAD_W-1:0]  RST_DEADBAND   = 15'd6554;
  localparam logic [SGAIN_W-1:0] RST_STICK_GAIN = 16'd250;
  localparam logic [STEP_W-1:0]  RST_RAMP_STEP  = 12'd2;
  localparam logic [BAND_W-1:0]  RST_SETTLE     = 16'd100;
  localparam logic [GAIN_W-1:0]  RST_KF         = 24'd2852127;
  localparam logic [GAIN_W-1:0]  RST_KP         = 24'd6711;
  localparam logic [GAIN_W-1:0]  RST_KI         = 24'd168;
  localparam logic [GAIN_W-1:0]  RST_KD         = 24'd0;

  // stream packing
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;

  typedef struct packed {
    logic        [DEAD_W-1:0]  deadband;
    logic        [SGAIN_W-1:0] stick_gain;
    logic        [STEP_W-1:0]  ramp_step;
    logic        [BAND_W-1:0]  settle_band;
    logic signed [GAIN_W-1:0]  kf;
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
  } cfg_t;

  // one strobe per datapath step
  typedef struct packed {
    logic latch;
    logic stick_mul;
    logic target;
    logic ramp;
    logic integ;
    logic prop;
    logic deriv;
    logic int_hi;
    logic int_lo;
    logic int_ph;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/rspl_regs.sv
// Configuration register file with reset defaults.
module rspl_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              we_i,
  input  logic [rspl_pkg::CFG_IDX_W-1:0]    idx_i,
  input  logic [rspl_pkg::CFG_DATA_W-1:0]   data_i,
  output rspl_pkg::cfg_t                    cfg_o
);

  rspl_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        rspl_pkg::REG_DEADBAND:   cfg_d.deadband    = data_i[rspl_pkg::DEAD_W-1:0];
        rspl_pkg::REG_STICK_GAIN: cfg_d.stick_gain  = data_i[rspl_pkg::SGAIN_W-1:0];
        rspl_pkg::REG_RAMP_STEP:  cfg_d.ramp_step   = data_i[rspl_pkg::STEP_W-1:0];
        rspl_pkg::REG_SETTLE:     cfg_d.settle_band = data_i[rspl_pkg::BAND_W-1:0];
        rspl_pkg::REG_KF:         cfg_d.kf          = data_i[rspl_pkg::GAIN_W-1:0];
        rspl_pkg::REG_KP:         cfg_d.kp          = data_i[rspl_pkg::GAIN_W-1:0];
        rspl_pkg::REG_KI:         cfg_d.ki          = data_i[rspl_pkg::GAIN_W-1:0];
        rspl_pkg::REG_KD:         cfg_d.kd          = data_i[rspl_pkg::GAIN_W-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband    <= rspl_pkg::RST_DEADBAND;
      cfg_q.stick_gain  <= rspl_pkg::RST_STICK_GAIN;
      cfg_q.ramp_step   <= rspl_pkg::RST_RAMP_STEP;
      cfg_q.settle_band <= rspl_pkg::RST_SETTLE;
      cfg_q.kf          <= rspl_pkg::RST_KF;
      cfg_q.kp          <= rspl_pkg::RST_KP;
      cfg_q.ki          <= rspl_pkg::RST_KI;
      cfg_q.kd          <= rspl_pkg::RST_KD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/rspl_ctrl.sv
// Sequencer that steps the datapath through one request and owns the output valid.
`include "ramped_setpoint_pid_lift_core_defines.svh"

module rspl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output rspl_pkg::cmd_t   cmd_o,
  output rspl_pkg::status_t status_o
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_STICK  = 11'b00000000010,
    ST_TARGET = 11'b00000000100,
    ST_RAMP   = 11'b00000001000,
    ST_INTEG  = 11'b00000010000,
    ST_PROP   = 11'b00000100000,
    ST_DERIV  = 11'b00001000000,
    ST_IHI    = 11'b00010000000,
    ST_ILO    = 11'b00100000000,
    ST_IPH    = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_STICK;
      ST_STICK:  state_d = ST_TARGET;
      ST_TARGET: state_d = ST_RAMP;
      ST_RAMP:   state_d = ST_INTEG;
      ST_INTEG:  state_d = ST_PROP;
      ST_PROP:   state_d = ST_DERIV;
      ST_DERIV:  state_d = ST_IHI;
      ST_IHI:    state_d = ST_ILO;
      ST_ILO:    state_d = ST_IPH;
      ST_IPH:    state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.latch     = accept;
    cmd_o.stick_mul = (state_q == ST_STICK);
    cmd_o.target    = (state_q == ST_TARGET);
    cmd_o.ramp      = (state_q == ST_RAMP);
    cmd_o.integ     = (state_q == ST_INTEG);
    cmd_o.prop      = (state_q == ST_PROP);
    cmd_o.deriv     = (state_q == ST_DERIV);
    cmd_o.int_hi    = (state_q == ST_IHI);
    cmd_o.int_lo    = (state_q == ST_ILO);
    cmd_o.int_ph    = (state_q == ST_IPH);
    cmd_o.load_out  = (state_q == ST_DONE) & out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.out_valid = out_valid_q;
  assign status_o.out_free  = out_free;

  `RSPL_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_STICK, "accepted request did not start")
  `RSPL_ASSERT_IMP(a_no_overwrite, cmd_o.load_out, !out_valid_q || out_ready_i, "result overwritten")
  `RSPL_ASSERT_IMP(a_valid_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "valid without done")

endmodule

FILE: hdl/rspl_dp.sv
// Datapath: target, ramp, error, integrator and shared-multiplier PID accumulate.
module rspl_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rspl_pkg::cmd_t                     cmd_i,
  input  rspl_pkg::cfg_t                     cfg_i,
  input  logic                               in_cmd_i,
  input  logic signed [rspl_pkg::STICK_W-1:0] in_stick_i,
  input  logic signed [rspl_pkg::POS_W-1:0]  in_target_i,
  input  logic signed [rspl_pkg::POS_W-1:0]  in_encoder_i,
  input  logic                               in_clear_i,
  output logic signed [rspl_pkg::PWR_W-1:0]  motor_power_o,
  output logic signed [rspl_pkg::POS_W-1:0]  setpoint_o,
  output logic signed [rspl_pkg::ERR_W-1:0]  position_error_o,
  output logic                               settled_o,
  output logic signed [rspl_pkg::POS_W-1:0]  commanded_target_o
);

  localparam int POS_W  = rspl_pkg::POS_W;
  localparam int ERR_W  = rspl_pkg::ERR_W;
  localparam int DIFF_W = rspl_pkg::DIFF_W;
  localparam int SUM_W  = rspl_pkg::SUM_W;
  localparam int ST_W   = rspl_pkg::ST_W;
  localparam int STR_W  = rspl_pkg::ST_RANGE_W;
  localparam int EXC_W  = rspl_pkg::EXC_W;
  localparam int ACC_W  = rspl_pkg::ACC_W;
  localparam int PROD_W = rspl_pkg::PROD_W;
  localparam int MA_W   = rspl_pkg::MUL_A_W;
  localparam int MB_W   = rspl_pkg::MUL_B_W;
  localparam int PH_W   = rspl_pkg::PH_W;
  localparam int HI_W   = rspl_pkg::HI_W;
  localparam int LO_W   = rspl_pkg::LO_SPLIT;
  localparam int PWR_W  = rspl_pkg::PWR_W;

  // stick target limits: integer part stays a valid position
  localparam logic signed [ST_W:0] ST_HI =
    {{(ST_W + 2 - STR_W){1'b0}}, {(STR_W - 1){1'b1}}};
  localparam logic signed [ST_W:0] ST_LO =
    {{(ST_W + 2 - STR_W){1'b1}}, {(STR_W - 1){1'b0}}};
  localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W - 1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] PWR_MAX = ACC_W'((1 << (PWR_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] PWR_MIN = -ACC_W'(1 << (PWR_W - 1));

  // latched request
  logic                             cmd_q;
  logic signed [rspl_pkg::STICK_W-1:0] stick_q;
  logic signed [POS_W-1:0]          tpos_q, enc_q;
  logic                             clr_q;

  // loop state
  logic signed [ST_W-1:0]  stick_tgt_q, stick_tgt_d;
  logic signed [POS_W-1:0] sp_q, sp_d;
  logic signed [SUM_W-1:0] esum_q, esum_d;
  logic signed [ERR_W-1:0] last_err_q, last_err_d;
  logic                    settled_q, settled_d;

  // per-request working registers
  logic signed [POS_W-1:0]  target_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PH_W-1:0]   ph_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  // output register
  logic signed [PWR_W-1:0] pwr_out_q;
  logic signed [POS_W-1:0] sp_out_q, tgt_out_q;
  logic signed [ERR_W-1:0] err_out_q;
  logic                    settled_out_q;

  // deadband
  logic signed [EXC_W-1:0] stick_x, dead_x, excess;
  always_comb begin
    stick_x = EXC_W'(stick_q);
    dead_x  = {2'b00, cfg_i.deadband};
    if (stick_x > dead_x) begin
      excess = stick_x - dead_x;
    end else if (stick_x < -dead_x) begin
      excess = stick_x + dead_x;
    end else begin
      excess = '0;
    end
  end

  // integrator split into a truncated high part and a signed low part
  logic                    hi_adj;
  logic signed [HI_W:0]    hi_wide;
  logic signed [HI_W-1:0]  int_hi;
  logic signed [LO_W:0]    int_lo;
  always_comb begin
    hi_adj  = esum_q[SUM_W-1] & (|esum_q[LO_W-1:0]);
    hi_wide = (HI_W + 1)'(esum_q[SUM_W-1:LO_W]) + (HI_W + 1)'(hi_adj);
    int_hi  = hi_wide[HI_W-1:0];
    int_lo  = {hi_adj, esum_q[LO_W-1:0]};
  end

  // shared multiplier operand selection
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_d;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.stick_mul) begin
      mul_a = MA_W'({1'b0, cfg_i.stick_gain});
      mul_b = MB_W'(excess);
    end else if (cmd_i.integ) begin
      mul_a = cfg_i.kp;
      mul_b = MB_W'(err_q);
    end else if (cmd_i.prop) begin
      mul_a = cfg_i.kd;
      mul_b = MB_W'(diff_q);
    end else if (cmd_i.deriv) begin
      mul_a = cfg_i.ki;
      mul_b = MB_W'(int_hi);
    end else if (cmd_i.int_hi) begin
      mul_a = cfg_i.ki;
      mul_b = MB_W'(int_lo);
    end
    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // stick target accumulate and saturate
  logic signed [ST_W:0]   st_sum;
  logic signed [ST_W-1:0] st_new;
  always_comb begin
    st_sum = (ST_W + 1)'(stick_tgt_q) + (ST_W + 1)'(prod_q);
    if (st_sum > ST_HI) begin
      st_new = ST_HI[ST_W-1:0];
    end else if (st_sum < ST_LO) begin
      st_new = ST_LO[ST_W-1:0];
    end else begin
      st_new = st_sum[ST_W-1:0];
    end
  end

  // ramp toward target, direction by target versus encoder
  logic signed [ERR_W-1:0] sp_x, tgt_x, enc_x, step_x, ramp_v;
  always_comb begin
    sp_x   = ERR_W'(sp_q);
    tgt_x  = ERR_W'(target_q);
    enc_x  = ERR_W'(enc_q);
    step_x = ERR_W'({1'b0, cfg_i.ramp_step});
    ramp_v = sp_x;
    if (tgt_x > enc_x) begin
      ramp_v = sp_x + step_x;
      if (ramp_v > tgt_x) ramp_v = tgt_x;
    end else if (tgt_x < enc_x) begin
      ramp_v = sp_x - step_x;
      if (ramp_v < tgt_x) ramp_v = tgt_x;
    end
  end

  // saturating integrator and settle window
  logic signed [SUM_W:0]  sum_x;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [DIFF_W-1:0] err_w, band_w;
  logic                    in_band;
  always_comb begin
    sum_x = (SUM_W + 1)'(esum_q) + (SUM_W + 1)'(err_q);
    if (sum_x > SUM_MAX) begin
      sum_new = SUM_MAX[SUM_W-1:0];
    end else if (sum_x < SUM_MIN) begin
      sum_new = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_new = sum_x[SUM_W-1:0];
    end
    err_w   = DIFF_W'(err_q);
    band_w  = DIFF_W'({1'b0, cfg_i.settle_band});
    in_band = (err_w > -band_w) && (err_w < band_w);
  end

  // integral term clamp decision
  logic sat_pos, sat_neg;
  assign sat_pos = (ph_q > rspl_pkg::INTEG_LIMIT);
  assign sat_neg = (ph_q < -rspl_pkg::INTEG_LIMIT);

  // accumulator
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.integ) begin
      acc_d = ACC_W'(cfg_i.kf);
    end else if (cmd_i.prop || cmd_i.deriv) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end else if (cmd_i.int_lo) begin
      if (sat_pos) begin
        acc_d = acc_q + rspl_pkg::INTEG_CLAMP;
      end else if (sat_neg) begin
        acc_d = acc_q - rspl_pkg::INTEG_CLAMP;
      end else begin
        acc_d = acc_q + ACC_W'(prod_q);
      end
    end else if (cmd_i.int_ph) begin
      if (!sat_pos && !sat_neg) begin
        acc_d = acc_q + (ACC_W'(ph_q) <<< LO_W);
      end
    end
  end

  // power: floor to Q15 and saturate
  logic signed [ACC_W-1:0] pwr_sh;
  logic signed [PWR_W-1:0] pwr_v;
  always_comb begin
    pwr_sh = acc_q >>> rspl_pkg::PWR_SHIFT;
    if (pwr_sh > PWR_MAX) begin
      pwr_v = PWR_MAX[PWR_W-1:0];
    end else if (pwr_sh < PWR_MIN) begin
      pwr_v = PWR_MIN[PWR_W-1:0];
    end else begin
      pwr_v = pwr_sh[PWR_W-1:0];
    end
  end

  // loop state next values
  always_comb begin
    stick_tgt_d = stick_tgt_q;
    sp_d        = sp_q;
    esum_d      = esum_q;
    last_err_d  = last_err_q;
    settled_d   = settled_q;
    if (cmd_i.target && !cmd_q) stick_tgt_d = st_new;
    if (cmd_i.ramp) sp_d = ramp_v[POS_W-1:0];
    if (cmd_i.integ) begin
      esum_d     = sum_new;
      last_err_d = err_q;
      settled_d  = (settled_q & ~clr_q) | in_band;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_tgt_q <= '0;
      sp_q        <= '0;
      esum_q      <= '0;
      last_err_q  <= '0;
      settled_q   <= 1'b0;
    end else begin
      stick_tgt_q <= stick_tgt_d;
      sp_q        <= sp_d;
      esum_q      <= esum_d;
      last_err_q  <= last_err_d;
      settled_q   <= settled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= in_cmd_i;
      stick_q <= in_stick_i;
      tpos_q  <= in_target_i;
      enc_q   <= in_encoder_i;
      clr_q   <= in_clear_i;
    end
    if (cmd_i.target) begin
      target_q <= cmd_q ? tpos_q : st_new[STR_W-1:rspl_pkg::Q_SHIFT];
    end
    if (cmd_i.ramp) begin
      // ramp_v already lies in the position range
      err_q <= ramp_v - enc_x;
    end
    if (cmd_i.integ) begin
      diff_q <= DIFF_W'(err_q) - DIFF_W'(last_err_q);
    end
    if (cmd_i.int_hi) begin
      ph_q <= prod_q[PH_W-1:0];
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.load_out) begin
      pwr_out_q     <= pwr_v;
      sp_out_q      <= sp_q;
      err_out_q     <= err_q;
      settled_out_q <= settled_q;
      tgt_out_q     <= target_q;
    end
  end

  assign motor_power_o      = pwr_out_q;
  assign setpoint_o         = sp_out_q;
  assign position_error_o   = err_out_q;
  assign settled_o          = settled_out_q;
  assign commanded_target_o = tgt_out_q;

endmodule

FILE: hdl/ramped_setpoint_pid_lift_core.sv
// Top level of the ramped-setpoint PID lift controller.
//
// Channel   Dir  Handshake                 Carries
// s_axis    in   tvalid/tready             tuser: cmd; tdata: stick, target, encoder, clear
// m_axis    out  tvalid/tready             tdata: power, setpoint, error, settled, target
// cfg       in   cfg_we_i, no wait         cfg_idx_i selects register, cfg_data_i value
//
// Each request is accepted, then runs through ten sequencer steps that
// share one 24x33 multiplier (stick gain, kp, kd, then ki on the high and low
// halves of the integrator), each product registered before it is added.
// The result lands in an output register, so the next request is taken while
// it waits; the sequencer only holds in its last step if that register is full.
// Reset (async, active low) zeroes the loop state and reloads register defaults.
module ramped_setpoint_pid_lift_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] stick, [35:16] target_position, [55:36] encoder_position,
  // [56] clear_settled, [63:57] zero
  input  logic [rspl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] cmd
  input  logic                                s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] motor_power, [35:16] setpoint, [56:36] position_error,
  // [57] settled, [77:58] commanded_target, [79:78] zero
  output logic [rspl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [rspl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rspl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  rspl_pkg::cfg_t    cfg;
  rspl_pkg::cmd_t    cmd;
  rspl_pkg::status_t status;

  logic signed [rspl_pkg::PWR_W-1:0] motor_power;
  logic signed [rspl_pkg::POS_W-1:0] setpoint;
  logic signed [rspl_pkg::ERR_W-1:0] position_error;
  logic                              settled;
  logic signed [rspl_pkg::POS_W-1:0] commanded_target;

  rspl_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  rspl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_o    (status)
  );

  // request fields unpacked straight from the bus; the datapath latches them on accept
  rspl_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .in_cmd_i           (s_axis_tuser),
    .in_stick_i         (s_axis_tdata[15:0]),
    .in_target_i        (s_axis_tdata[35:16]),
    .in_encoder_i       (s_axis_tdata[55:36]),
    .in_clear_i         (s_axis_tdata[56]),
    .motor_power_o      (motor_power),
    .setpoint_o         (setpoint),
    .position_error_o   (position_error),
    .settled_o          (settled),
    .commanded_target_o (commanded_target)
  );

  assign m_axis_tvalid = status.out_valid;
  assign m_axis_tdata  = {2'b00, commanded_target, settled, position_error,
                          setpoint, motor_power};

endmodule

FILE: dv/ramped_setpoint_pid_lift_core_tb.sv
// Self-checking stream testbench for the ramped-setpoint PID lift controller core.
`timescale 1ns / 100ps

module ramped_setpoint_pid_lift_core_tb;

  // ---------------------------------------------------------------------------
  // Types and constants
  // ---------------------------------------------------------------------------
  localparam int STICK_W    = rspl_pkg::STICK_W;
  localparam int POS_W      = rspl_pkg::POS_W;
  localparam int ERR_W      = rspl_pkg::ERR_W;
  localparam int PWR_W      = rspl_pkg::PWR_W;
  localparam int SUM_W      = rspl_pkg::SUM_W;
  localparam int Q_SHIFT    = rspl_pkg::Q_SHIFT;
  localparam int PWR_SHIFT  = rspl_pkg::PWR_SHIFT;
  localparam int IN_DATA_W  = rspl_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = rspl_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W  = rspl_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rspl_pkg::CFG_DATA_W;
  localparam int GAIN_W     = rspl_pkg::GAIN_W;
  localparam int DEAD_W     = rspl_pkg::DEAD_W;
  localparam int SGAIN_W    = rspl_pkg::SGAIN_W;
  localparam int STEP_W     = rspl_pkg::STEP_W;
  localparam int BAND_W     = rspl_pkg::BAND_W;

  // tuser selects where the target comes from
  typedef enum bit {
    CMD_STICK  = 1'b0,
    CMD_TARGET = 1'b1
  } lift_cmd_e;

  typedef struct packed {
    lift_cmd_e                 cmd;
    logic signed [STICK_W-1:0] stick;
    logic signed [POS_W-1:0]   tpos;
    logic signed [POS_W-1:0]   enc;
    logic                      clr;
  } request_t;

  typedef struct packed {
    logic signed [PWR_W-1:0] power;
    logic signed [POS_W-1:0] setpoint;
    logic signed [ERR_W-1:0] pos_err;
    logic                    settled;
    logic signed [POS_W-1:0] tgt;
  } result_t;

  localparam longint POS_MAX    = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN    = -POS_MAX - 1;
  localparam longint SUM_MAX    = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN    = -SUM_MAX - 1;
  localparam longint STICK_HI   = ((POS_MAX + 1) <<< Q_SHIFT) - 1;
  localparam longint STICK_LO   = POS_MIN * (64'sd1 <<< Q_SHIFT);
  localparam longint HALF_SPLIT = 64'sd1 <<< 32;
  localparam longint PH_LIMIT   = 64'sd1 <<< 28;
  localparam longint INTEG_BIG  = 64'sd1 <<< 60;
  localparam longint PWR_MAX    = 32767;
  localparam longint PWR_MIN    = -32768;

  // quiet time that wait_idle adds after the last result
  localparam int     SETTLE_CYCLES = 16;
  localparam longint CYCLE_LIMIT   = 400000;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  always #2 clk_i = ~clk_i;

  ramped_setpoint_pid_lift_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Controller shadow: config copy on register writes, loop state per request
  // ---------------------------------------------------------------------------
  rspl_pkg::cfg_t lift_cfg;
  longint  lift_stick_q15;   // joystick target, Q15 ticks
  longint  lift_setpoint;
  longint  lift_err_sum;
  longint  lift_prev_err;
  bit      lift_settled;

  result_t pending_results[$];
  int      n_errors;
  longint  cycle_cnt;

  // knobs shared by the sender, the receiver and the tests
  bit      src_idle_en;
  bit      snk_idle_en;
  int      snk_hold_cycles;

  function automatic longint sat_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // One control step: target, ramp, error, integrator, PID+FF power, settle flag.
  function automatic result_t predict_lift_step(input request_t rq);
    longint  stick_v, enc_v, dead_v, band_v, excess, tgt, err;
    longint  pid_ff, integ, total, pwr, hi, lo, ph;
    result_t r;
    stick_v = longint'(rq.stick);
    enc_v   = longint'(rq.enc);
    dead_v  = longint'(lift_cfg.deadband);
    band_v  = longint'(lift_cfg.settle_band);

    if (rq.clr) lift_settled = 1'b0;

    if (rq.cmd == CMD_STICK) begin
      // deflection past the deadband, measured from its edge
      excess = 0;
      if (stick_v > dead_v) excess = stick_v - dead_v;
      else if (stick_v < -dead_v) excess = stick_v + dead_v;
      lift_stick_q15 = lift_stick_q15 + excess * longint'(lift_cfg.stick_gain);
      if (lift_stick_q15 > STICK_HI) lift_stick_q15 = STICK_HI;
      if (lift_stick_q15 < STICK_LO) lift_stick_q15 = STICK_LO;
      tgt = lift_stick_q15 >>> Q_SHIFT;  // floor to whole ticks
    end else begin
      tgt = longint'(rq.tpos);
    end

    // direction follows target vs encoder, then clamp at the target
    if (tgt > enc_v) begin
      lift_setpoint = lift_setpoint + longint'(lift_cfg.ramp_step);
      if (lift_setpoint > tgt) lift_setpoint = tgt;
    end else if (tgt < enc_v) begin
      lift_setpoint = lift_setpoint - longint'(lift_cfg.ramp_step);
      if (lift_setpoint < tgt) lift_setpoint = tgt;
    end

    err = lift_setpoint - enc_v;

    if (err > 0 && lift_err_sum > SUM_MAX - err) lift_err_sum = SUM_MAX;
    else if (err < 0 && lift_err_sum < SUM_MIN - err) lift_err_sum = SUM_MIN;
    else lift_err_sum = lift_err_sum + err;

    pid_ff = longint'(lift_cfg.kf) + longint'(lift_cfg.kp) * err
           + longint'(lift_cfg.kd) * (err - lift_prev_err);

    // ki * sum split in 32-bit halves; a huge high part pins to a big value
    hi = lift_err_sum / HALF_SPLIT;
    lo = lift_err_sum - hi * HALF_SPLIT;
    ph = longint'(lift_cfg.ki) * hi;
    if (ph > PH_LIMIT) integ = INTEG_BIG;
    else if (ph < -PH_LIMIT) integ = -INTEG_BIG;
    else integ = ph * HALF_SPLIT + longint'(lift_cfg.ki) * lo;

    total = pid_ff + integ;
    pwr   = total >>> PWR_SHIFT;  // Q24 -> Q15, toward minus infinity
    if (pwr > PWR_MAX) pwr = PWR_MAX;
    if (pwr < PWR_MIN) pwr = PWR_MIN;

    lift_prev_err = err;
    if (err > -band_v && err < band_v) lift_settled = 1'b1;

    r.power    = pwr[PWR_W-1:0];
    r.setpoint = lift_setpoint[POS_W-1:0];
    r.pos_err  = err[ERR_W-1:0];
    r.settled  = lift_settled;
    r.tgt      = tgt[POS_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------
  function automatic request_t make_request(input lift_cmd_e c, input int stick,
                                            input int tpos, input int enc,
                                            input bit clr);
    request_t rq;
    rq.cmd   = c;
    rq.stick = stick[STICK_W-1:0];
    rq.tpos  = tpos[POS_W-1:0];
    rq.enc   = enc[POS_W-1:0];
    rq.clr   = clr;
    return rq;
  endfunction

  // Mostly encoder near the setpoint and targets nearby, so the loop settles,
  // ramps and tracks; the rest spans the full field ranges.
  function automatic request_t rand_request();
    request_t rq;
    longint   dead_v;
    int       sel;
    dead_v = longint'(lift_cfg.deadband);
    rq.cmd = $urandom_range(0, 1) ? CMD_TARGET : CMD_STICK;
    rq.clr = ($urandom_range(0, 7) == 0);

    sel = int'($urandom_range(0, 9));
    if (sel < 6) begin
      rq.enc = POS_W'(sat_pos(lift_setpoint + int'($urandom_range(0, 600)) - 300));
    end else if (sel == 6) begin
      rq.enc = POS_W'($urandom_range(0, 1) ? POS_MAX : POS_MIN);
    end else begin
      rq.enc = POS_W'($urandom);
    end

    sel = int'($urandom_range(0, 9));
    if (sel < 5) begin
      rq.tpos = POS_W'(sat_pos(longint'(rq.enc) + int'($urandom_range(0, 8000)) - 4000));
    end else if (sel == 5) begin
      rq.tpos = rq.enc;
    end else if (sel == 6) begin
      rq.tpos = POS_W'($urandom_range(0, 1) ? POS_MAX : POS_MIN);
    end else begin
      rq.tpos = POS_W'($urandom);
    end

    case ($urandom_range(0, 7))
      0, 1:    rq.stick = STICK_W'($urandom);
      2:       rq.stick = STICK_W'(dead_v + $urandom_range(0, 1));
      3:       rq.stick = STICK_W'(-dead_v - $urandom_range(0, 1));
      4:       rq.stick = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      5:       rq.stick = '0;
      default: rq.stick = STICK_W'(int'($urandom_range(0, 20000)) - 10000);
    endcase
    return rq;
  endfunction

  function automatic logic signed [GAIN_W-1:0] rand_gain(input int mag);
    case ($urandom_range(0, 4))
      0:       return {1'b1, {(GAIN_W - 1){1'b0}}};
      1:       return {1'b0, {(GAIN_W - 1){1'b1}}};
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'(int'($urandom_range(0, 2 * mag)) - mag);
    endcase
  endfunction

  function automatic rspl_pkg::cfg_t random_cfg();
    rspl_pkg::cfg_t c;
    case ($urandom_range(0, 3))
      0:       c.deadband = '0;
      1:       c.deadband = '1;
      2:       c.deadband = DEAD_W'($urandom);
      default: c.deadband = DEAD_W'($urandom_range(1000, 10000));
    endcase
    case ($urandom_range(0, 3))
      0:       c.stick_gain = '0;
      1:       c.stick_gain = '1;
      2:       c.stick_gain = SGAIN_W'($urandom);
      default: c.stick_gain = SGAIN_W'($urandom_range(50, 2000));
    endcase
    case ($urandom_range(0, 3))
      0:       c.ramp_step = '0;
      1:       c.ramp_step = '1;
      2:       c.ramp_step = STEP_W'($urandom);
      default: c.ramp_step = STEP_W'($urandom_range(1, 50));
    endcase
    case ($urandom_range(0, 3))
      0:       c.settle_band = '0;
      1:       c.settle_band = '1;
      2:       c.settle_band = BAND_W'($urandom);
      default: c.settle_band = BAND_W'($urandom_range(20, 500));
    endcase
    c.kf = rand_gain(2852127);
    c.kp = rand_gain(20000);
    c.ki = rand_gain(400);
    c.kd = rand_gain(20000);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------
  // Register write; bits above the register width carry random junk.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
    logic [CFG_DATA_W-1:0] mask, word;
    mask = ~({CFG_DATA_W{1'b1}} << width);
    word = (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= word;
    @(posedge clk_i);
    case (idx)
      rspl_pkg::REG_DEADBAND:   lift_cfg.deadband    = word[DEAD_W-1:0];
      rspl_pkg::REG_STICK_GAIN: lift_cfg.stick_gain  = word[SGAIN_W-1:0];
      rspl_pkg::REG_RAMP_STEP:  lift_cfg.ramp_step   = word[STEP_W-1:0];
      rspl_pkg::REG_SETTLE:     lift_cfg.settle_band = word[BAND_W-1:0];
      rspl_pkg::REG_KF:         lift_cfg.kf          = word[GAIN_W-1:0];
      rspl_pkg::REG_KP:         lift_cfg.kp          = word[GAIN_W-1:0];
      rspl_pkg::REG_KI:         lift_cfg.ki          = word[GAIN_W-1:0];
      rspl_pkg::REG_KD:         lift_cfg.kd          = word[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Caller guarantees the core is idle.
  task automatic apply_config(input rspl_pkg::cfg_t c);
    write_reg(rspl_pkg::REG_DEADBAND,   CFG_DATA_W'(c.deadband),    DEAD_W);
    write_reg(rspl_pkg::REG_STICK_GAIN, CFG_DATA_W'(c.stick_gain),  SGAIN_W);
    write_reg(rspl_pkg::REG_RAMP_STEP,  CFG_DATA_W'(c.ramp_step),   STEP_W);
    write_reg(rspl_pkg::REG_SETTLE,     CFG_DATA_W'(c.settle_band), BAND_W);
    write_reg(rspl_pkg::REG_KF,         CFG_DATA_W'(c.kf),          GAIN_W);
    write_reg(rspl_pkg::REG_KP,         CFG_DATA_W'(c.kp),          GAIN_W);
    write_reg(rspl_pkg::REG_KI,         CFG_DATA_W'(c.ki),          GAIN_W);
    write_reg(rspl_pkg::REG_KD,         CFG_DATA_W'(c.kd),          GAIN_W);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one request; returns at the edge that accepted it, with tvalid
  // still high so a back-to-back request needs no toggle.
  task automatic send_request(input request_t rq);
    int gap;
    gap = src_idle_en ? int'($urandom_range(0, 7)) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - 57){1'b0}}, rq.clr, rq.enc, rq.tpos, rq.stick};
    s_axis_tuser  <= rq.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_lift_step(rq));
  endtask

  // Drop tvalid and wait for every result, then let the pipeline go quiet.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] d);
    result_t want, got;
    got.power    = d[15:0];
    got.setpoint = d[35:16];
    got.pos_err  = d[56:36];
    got.settled  = d[57];
    got.tgt      = d[77:58];
    if (pending_results.size() == 0) begin
      n_errors++;
      $display("%0t: result with no request outstanding, expected none, actual %h",
               $time, d);
    end else begin
      want = pending_results.pop_front();
      check_field("motor_power",      longint'(want.power),    longint'(got.power));
      check_field("setpoint",         longint'(want.setpoint), longint'(got.setpoint));
      check_field("position_error",   longint'(want.pos_err),  longint'(got.pos_err));
      check_field("settled",          longint'(want.settled),  longint'(got.settled));
      check_field("commanded_target", longint'(want.tgt),      longint'(got.tgt));
      check_field("padding",          0,                 longint'(d[OUT_DATA_W-1:78]));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls per result, plus a one-shot long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = snk_idle_en ? int'($urandom_range(0, 7)) : 0;
      if (snk_hold_cycles > 0) begin
        stall = snk_hold_cycles;
        snk_hold_cycles = 0;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result(m_axis_tdata);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ramped_setpoint_pid_lift_core_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset defaults, joystick path: deadband edges and full-scale deflection.
  task automatic test_stick_deadband();
    int dead;
    dead = int'(lift_cfg.deadband);
    send_request(make_request(CMD_STICK, 0, 0, 0, 1'b0));  // target == encoder: hold
    send_request(make_request(CMD_STICK, dead, 0, 0, 1'b1));
    send_request(make_request(CMD_STICK, dead + 1, 0, 0, 1'b0));
    send_request(make_request(CMD_STICK, -dead, 0, 0, 1'b0));
    send_request(make_request(CMD_STICK, -dead - 1, 0, 0, 1'b0));
    send_request(make_request(CMD_STICK, 32767, 0, 0, 1'b0));
    send_request(make_request(CMD_STICK, -32768, 0, 5, 1'b1));
    send_request(make_request(CMD_STICK, 32767, 0, int'(POS_MIN), 1'b0));
    send_request(make_request(CMD_STICK, -32768, 0, int'(POS_MAX), 1'b0));
  endtask

  // Direct targets at the range ends and a target equal to the encoder.
  task automatic test_direct_target();
    send_request(make_request(CMD_TARGET, 0, int'(POS_MAX), int'(POS_MIN), 1'b0));
    send_request(make_request(CMD_TARGET, 12345, int'(POS_MIN), int'(POS_MAX), 1'b0));
    send_request(make_request(CMD_TARGET, -1, 1000, 1000, 1'b1));
    send_request(make_request(CMD_TARGET, 0, 0, 0, 1'b1));
  endtask

  // Extreme register settings: overshoot clamping with a huge step, stick target
  // saturation both ways, then the opposite extremes.
  task automatic test_config_extremes();
    rspl_pkg::cfg_t c;
    wait_idle();
    c.deadband    = '0;
    c.stick_gain  = '1;
    c.ramp_step   = '1;
    c.settle_band = '0;
    c.kf = {1'b0, {(GAIN_W - 1){1'b1}}};
    c.kp = {1'b0, {(GAIN_W - 1){1'b1}}};
    c.ki = {1'b0, {(GAIN_W - 1){1'b1}}};
    c.kd = {1'b0, {(GAIN_W - 1){1'b1}}};
    apply_config(c);
    send_request(make_request(CMD_TARGET, 0, 100, 0, 1'b0));
    // setpoint above a target that is still above the encoder
    send_request(make_request(CMD_TARGET, 0, 50, 0, 1'b0));
    send_request(make_request(CMD_TARGET, 0, -50, 0, 1'b0));
    // setpoint below a target that is still below the encoder
    send_request(make_request(CMD_TARGET, 0, -20, 0, 1'b0));
    send_request(make_request(CMD_TARGET, 0, -10, -200, 1'b0));
    // stick target pinned at the top, then at the bottom
    repeat (9) send_request(make_request(CMD_STICK, 32767, 0, 0, 1'b0));
    repeat (17) send_request(make_request(CMD_STICK, -32768, 0, 0, 1'b0));

    wait_idle();
    c.deadband    = '1;
    c.stick_gain  = '0;
    c.ramp_step   = '0;
    c.settle_band = '1;
    c.kf = {1'b1, {(GAIN_W - 1){1'b0}}};
    c.kp = {1'b1, {(GAIN_W - 1){1'b0}}};
    c.ki = {1'b1, {(GAIN_W - 1){1'b0}}};
    c.kd = {1'b1, {(GAIN_W - 1){1'b0}}};
    apply_config(c);
    send_request(make_request(CMD_STICK, 32767, 0, 0, 1'b1));
    send_request(make_request(CMD_STICK, -32768, 0, 7, 1'b0));
    repeat (6) send_request(rand_request());
  endtask

  // Receiver holds off while the sender keeps offering back to back, so the
  // core fills and stalls its input; then it drains fully and the burst repeats.
  task automatic test_backpressure();
    wait_idle();
    apply_config(random_cfg());
    src_idle_en = 1'b0;
    snk_idle_en = 1'b1;
    snk_hold_cycles = 200;
    repeat (24) send_request(rand_request());
    wait_idle();
    repeat (24) send_request(rand_request());
  endtask

  // Random settings per phase, with idle patterns varied inside each phase.
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      apply_config(random_cfg());
      for (int n = 0; n < 150; n++) begin
        if (n % 50 == 0) begin
          src_idle_en = ($urandom_range(0, 3) != 0);
          snk_idle_en = ($urandom_range(0, 3) != 0);
        end
        send_request(rand_request());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    n_errors        = 0;
    cycle_cnt       = 0;
    src_idle_en     = 1'b1;
    snk_idle_en     = 1'b1;
    snk_hold_cycles = 0;

    lift_cfg.deadband    = rspl_pkg::RST_DEADBAND;
    lift_cfg.stick_gain  = rspl_pkg::RST_STICK_GAIN;
    lift_cfg.ramp_step   = rspl_pkg::RST_RAMP_STEP;
    lift_cfg.settle_band = rspl_pkg::RST_SETTLE;
    lift_cfg.kf          = rspl_pkg::RST_KF;
    lift_cfg.kp          = rspl_pkg::RST_KP;
    lift_cfg.ki          = rspl_pkg::RST_KI;
    lift_cfg.kd          = rspl_pkg::RST_KD;
    lift_stick_q15 = 0;
    lift_setpoint  = 0;
    lift_err_sum   = 0;
    lift_prev_err  = 0;
    lift_settled   = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_stick_deadband();
    test_direct_target();
    test_config_extremes();
    test_backpressure();
    test_random_phases();

    wait_idle();
    if (n_errors == 0) begin
      $display("ramped_setpoint_pid_lift_core_tb: done, clean");
    end else begin
      $display("ramped_setpoint_pid_lift_core_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/rspl_pkg.sv
hdl/rspl_regs.sv
hdl/rspl_ctrl.sv
hdl/rspl_dp.sv
hdl/ramped_setpoint_pid_lift_core.sv
dv/ramped_setpoint_pid_lift_core_tb.sv
